@@ sv/itp_pkg.sv @@
package itp_pkg;

    localparam int StackDepthDef = 32;

    typedef logic [2:0] t_kind;

    // Input token codes.
    localparam t_kind KIND_OPERAND = 3'd0;
    localparam t_kind KIND_LPAREN  = 3'd1;
    localparam t_kind KIND_RPAREN  = 3'd2;
    localparam t_kind KIND_ADD     = 3'd3;
    localparam t_kind KIND_SUB     = 3'd4;
    localparam t_kind KIND_MUL     = 3'd5;
    localparam t_kind KIND_DIV     = 3'd6;
    localparam t_kind KIND_END     = 3'd7;

    // Output token codes.
    localparam t_kind OUT_OPERAND = 3'd0;
    localparam t_kind OUT_LPAREN  = 3'd5;
    localparam t_kind OUT_END     = 3'd6;

    typedef struct packed {
        t_kind       token_kind;
        logic [31:0] operand_value;
    } t_itp_in;

    typedef struct packed {
        t_kind       out_kind;
        logic [31:0] out_value;
        logic        overflow;
        logic        last;
    } t_itp_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RPAREN,
        S_OPER,
        S_FLUSH,
        S_FINISH
    } t_itp_state;

    typedef enum logic [1:0] {
        EMIT_OPERAND,
        EMIT_TOP,
        EMIT_END
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      push;
        logic      pop;
        logic      emit;
        t_emit_sel emit_sel;
        logic      finish;
        logic      clear;
    } t_itp_cmd;

    typedef struct packed {
        logic  count_zero;
        t_kind top_kind;
        t_kind tok_kind;
        logic  hold_valid;
        logic  out_free;
    } t_itp_status;

    function automatic logic [1:0] prec_of(input t_kind kind);
        logic [1:0] prec;
        case (kind)
            KIND_LPAREN, KIND_RPAREN: prec = 2'd0;
            KIND_ADD, KIND_SUB:       prec = 2'd1;
            default:                  prec = 2'd2;
        endcase
        return prec;
    endfunction

    function automatic t_kind out_code(input t_kind kind);
        t_kind code;
        if (kind == KIND_LPAREN) begin
            code = OUT_LPAREN;
        end else begin
            code = kind - 3'd2;
        end
        return code;
    endfunction

endpackage

@@ sv/itp_ctrl.sv @@
module itp_ctrl
    import itp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_kind       i_in_kind,
    input  t_itp_status i_status,
    output t_itp_cmd    o_cmd,
    output logic        o_in_stall
);

    t_itp_state r_state;
    t_itp_state n_state;
    logic       can_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new beat may enter the hold stage if it is empty or its content can move on.
    assign can_emit   = !i_status.hold_valid || i_status.out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_kind)
                        KIND_OPERAND: begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EMIT_OPERAND;
                            n_state        = S_FINISH;
                        end
                        KIND_LPAREN: begin
                            o_cmd.push = 1'b1;
                        end
                        KIND_RPAREN: begin
                            n_state = S_RPAREN;
                        end
                        KIND_END: begin
                            n_state = S_FLUSH;
                        end
                        default: begin
                            n_state = S_OPER;
                        end
                    endcase
                end
            end
            S_RPAREN: begin
                if (i_status.count_zero) begin
                    n_state = S_FINISH;
                end else if (i_status.top_kind == KIND_LPAREN) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_FINISH;
                end else if (can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_TOP;
                    o_cmd.pop      = 1'b1;
                end
            end
            S_OPER: begin
                if (!i_status.count_zero &&
                    (prec_of(i_status.tok_kind) <= prec_of(i_status.top_kind))) begin
                    if (can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_TOP;
                        o_cmd.pop      = 1'b1;
                    end
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_FLUSH: begin
                if (can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.count_zero) begin
                        o_cmd.emit_sel = EMIT_TOP;
                        o_cmd.pop      = 1'b1;
                    end else begin
                        o_cmd.emit_sel = EMIT_END;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!i_status.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/itp_dp.sv @@
module itp_dp
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_itp_cmd    i_cmd,
    input  t_itp_in     i_in_data,
    input  logic        i_out_stall,
    output t_itp_status o_status,
    output logic        o_out_valid,
    output t_itp_out    o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_kind          r_mem [STACK_DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  n_dec;
    logic           r_ovf;
    logic           n_ovf;
    t_kind          r_tok_kind;
    t_kind          r_top;
    logic           r_hold_valid;
    logic           n_hold_valid;
    t_itp_out       r_hold;
    t_itp_out       n_hold;
    logic           r_out_valid;
    logic           n_out_valid;
    t_itp_out       r_out;
    t_itp_out       n_out;
    t_itp_out       emit_beat;
    t_kind          push_kind;
    logic           full;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           out_free;

    assign full      = (r_count == CW'(STACK_DEPTH));
    assign push_kind = i_cmd.load ? i_in_data.token_kind : r_tok_kind;
    assign wr_en     = i_cmd.push && !full;
    assign wr_addr   = r_count[AW-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else if (wr_en) begin
            n_count = r_count + CW'(1);
        end
        n_dec   = n_count - CW'(1);
        rd_addr = n_dec[AW-1:0];
    end

    always_comb begin
        n_ovf = r_ovf;
        if (i_cmd.clear) begin
            n_ovf = 1'b0;
        end else if (i_cmd.push && full) begin
            n_ovf = 1'b1;
        end
    end

    // The read port always fetches the entry that will be on top next cycle,
    // so one entry can be popped every cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= push_kind;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_top <= push_kind;
        end else begin
            r_top <= r_mem[rd_addr];
        end
    end

    always_comb begin
        emit_beat = '0;
        case (i_cmd.emit_sel)
            EMIT_OPERAND: begin
                emit_beat.out_kind  = OUT_OPERAND;
                emit_beat.out_value = i_in_data.operand_value;
            end
            EMIT_TOP: begin
                emit_beat.out_kind = out_code(r_top);
            end
            EMIT_END: begin
                emit_beat.out_kind = OUT_END;
                emit_beat.overflow = r_ovf;
            end
            default: begin
                emit_beat = '0;
            end
        endcase
    end

    // A beat waits in the hold stage until the next one shows whether it is the last.
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if ((i_cmd.emit && r_hold_valid) || i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_out       = r_hold;
            n_out.last  = i_cmd.finish;
        end
        if (i_cmd.emit) begin
            n_hold_valid = 1'b1;
            n_hold       = emit_beat;
        end else if (i_cmd.finish) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tok_kind <= i_in_data.token_kind;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.top_kind   = r_top;
    assign o_status.tok_kind   = r_tok_kind;
    assign o_status.hold_valid = r_hold_valid;
    assign o_status.out_free   = out_free;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from empty stack");

    a_hold_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.emit && r_hold_valid) || i_cmd.finish) |-> out_free)
        else $error("held beat overwritten while output is full");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.out_kind == OUT_END)) |-> r_out.last)
        else $error("end marker without last");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> ((r_count == '0) && !r_ovf))
        else $error("state not cleared after end of expression");

endmodule

@@ sv/infix_to_postfix_converter_unit.sv @@
// Shunting-yard infix-to-postfix converter. Each input beat is one infix token; each
// output beat is one postfix token, with last set on the final beat caused by an input
// and, on the end marker, a sticky flag telling whether a push was dropped because the
// operator stack was full. A '(' is pushed at once and an operand goes to the hold stage.
// A ')' pops and emits stack entries until it finds its '(', which is popped but not
// emitted, or empties the stack. An operator pops and emits entries of equal or higher
// precedence, then is pushed. End of expression pops and emits every entry, then its
// marker. The operator stack memory gives one pop per cycle, but popping waits while
// the output stalls. No new token is taken while one is still being worked on.
module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDef
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_itp_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_itp_out o_out_data
);

    t_itp_cmd    cmd;
    t_itp_status status;

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.token_kind),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
